FILE: rtl/core/prr_pkg.sv
// Shared types and codes for the second-chance replacement list.
// Used by prr_cell, prr_ctrl and page_replacement_ref_reorder_top; no dependencies.
package prr_pkg;

  localparam int unsigned FramesDef = 64;
  localparam int unsigned FRAME_W   = 6;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned OCC_W     = 7;

  // Request kinds carried on the input beat.
  localparam logic [KIND_W-1:0] KIND_INSERT    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REFERENCE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_VICTIM    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd3;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD   = 3'd0,
    CELL_WRITE  = 3'd1,
    CELL_SHIFT  = 3'd2,
    CELL_ROTATE = 3'd3,
    CELL_SORT   = 3'd4,
    CELL_CLEAR  = 3'd5
  } cell_op_e;

  typedef struct packed {
    cell_op_e           op;
    logic               set_ref;
    logic               phase;
    logic [FRAME_W-1:0] wr_frame;
    logic               wr_ref;
  } cell_cmd_t;

endpackage

FILE: rtl/core/prr_cell.sv
// One list position: a frame number and its referenced bit.
// Depends on prr_pkg; instantiated in a row by page_replacement_ref_reorder_top.
module prr_cell
  import prr_pkg::*;
#(
  parameter int unsigned FRAMES = FramesDef,
  parameter int unsigned IDX    = 0
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cell_cmd_t                    cmd_i,
  input  logic [$clog2(FRAMES+1)-1:0]  cnt_i,
  input  logic [FRAME_W-1:0]           head_frame_i,
  input  logic                         head_ref_i,
  input  logic [FRAME_W-1:0]           right_frame_i,
  input  logic                         right_ref_i,
  input  logic [FRAME_W-1:0]           left_frame_i,
  input  logic                         left_ref_i,
  output logic [FRAME_W-1:0]           frame_o,
  output logic                         ref_o
);

  localparam int unsigned CntW = $clog2(FRAMES + 1);
  localparam logic [CntW-1:0] IdxC   = CntW'(IDX);
  localparam logic [CntW-1:0] IdxP1C = CntW'(IDX + 1);
  localparam logic            IdxOdd = 1'(IDX % 2);

  logic [FRAME_W-1:0] frame_q, frame_d;
  logic               ref_q, ref_d;

  always_comb begin
    frame_d = frame_q;
    ref_d   = ref_q;
    unique case (cmd_i.op)
      CELL_HOLD: begin
      end
      CELL_WRITE: begin
        if (cnt_i == IdxC) begin
          frame_d = cmd_i.wr_frame;
          ref_d   = cmd_i.wr_ref;
        end
      end
      CELL_SHIFT: begin
        frame_d = right_frame_i;
        ref_d   = right_ref_i;
      end
      CELL_ROTATE: begin
        // The tail of the ring takes the head; everyone else moves one toward the head.
        if (cnt_i == IdxP1C) begin
          frame_d = head_frame_i;
          ref_d   = head_ref_i | cmd_i.set_ref;
        end else begin
          frame_d = right_frame_i;
          ref_d   = right_ref_i;
        end
      end
      CELL_SORT: begin
        // Odd-even transposition: swap only a set bit ahead of a clear one, which keeps order.
        if (cmd_i.phase == IdxOdd) begin
          if ((IdxP1C < cnt_i) && ref_q && !right_ref_i) begin
            frame_d = right_frame_i;
            ref_d   = right_ref_i;
          end
        end else begin
          if ((IdxC < cnt_i) && left_ref_i && !ref_q) begin
            frame_d = left_frame_i;
            ref_d   = left_ref_i;
          end
        end
      end
      CELL_CLEAR: begin
        ref_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 1'b0;
    end else begin
      ref_q <= ref_d;
    end
  end

  assign frame_o = frame_q;
  assign ref_o   = ref_q;

endmodule

FILE: rtl/core/prr_ctrl.sv
// Sequencer for the replacement list: decodes requests, steps the cell row, holds the result.
// Depends on prr_pkg; drives the prr_cell row through a cell_cmd_t broadcast.
module prr_ctrl
  import prr_pkg::*;
#(
  parameter int unsigned FRAMES = FramesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [KIND_W-1:0]            in_kind_i,
  input  logic [FRAME_W-1:0]           in_frame_i,
  input  logic                         in_iref_i,
  input  logic [FRAME_W-1:0]           head_frame_i,
  output cell_cmd_t                    cmd_o,
  output logic [$clog2(FRAMES+1)-1:0]  cnt_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [FRAME_W-1:0]           out_victim_frame_o,
  output logic                         out_victim_valid_o,
  output logic [STATUS_W-1:0]          out_status_o,
  output logic [OCC_W-1:0]             out_occ_o
);

  localparam int unsigned CntW = $clog2(FRAMES + 1);
  localparam logic [CntW-1:0] FramesC = CntW'(FRAMES);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_SORT = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     steps_q, steps_d;
  logic                phase_q, phase_d;
  logic                found_q, found_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [FRAME_W-1:0]  vf_q, vf_d;
  logic                vv_q, vv_d;
  logic [STATUS_W-1:0] st_q, st_d;
  logic                out_valid_q, out_valid_d;
  logic [FRAME_W-1:0]  out_vf_q, out_vf_d;
  logic                out_vv_q, out_vv_d;
  logic [STATUS_W-1:0] out_st_q, out_st_d;
  logic [OCC_W-1:0]    out_occ_q, out_occ_d;
  logic                hit;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    steps_d     = steps_q;
    phase_d     = phase_q;
    found_d     = found_q;
    kind_d      = kind_q;
    frame_d     = frame_q;
    vf_d        = vf_q;
    vv_d        = vv_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_vf_d    = out_vf_q;
    out_vv_d    = out_vv_q;
    out_st_d    = out_st_q;
    out_occ_d   = out_occ_q;
    hit         = (head_frame_i == frame_q) && !found_q;
    cmd_o       = '{op: CELL_HOLD, set_ref: 1'b0, phase: phase_q,
                    wr_frame: in_frame_i, wr_ref: in_iref_i};

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_kind_i;
          frame_d = in_frame_i;
          vf_d    = '0;
          vv_d    = 1'b0;
          st_d    = STATUS_OK;
          found_d = 1'b0;
          steps_d = cnt_q;
          phase_d = 1'b0;
          state_d = ST_DONE;
          unique case (in_kind_i)
            KIND_INSERT: begin
              if (cnt_q == FramesC) begin
                st_d = STATUS_FULL;
              end else begin
                cmd_o.op = CELL_WRITE;
                cnt_d    = cnt_q + 1'b1;
              end
            end
            KIND_VICTIM: begin
              if (cnt_q == '0) begin
                st_d = STATUS_EMPTY;
              end else begin
                vf_d     = head_frame_i;
                vv_d     = 1'b1;
                cmd_o.op = CELL_SHIFT;
                cnt_d    = cnt_q - 1'b1;
              end
            end
            KIND_REMOVE, KIND_REFERENCE: begin
              state_d = ST_WALK;
            end
            KIND_TICK: begin
              state_d = ST_SORT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_WALK: begin
        // Every entry passes the head once; a remove drops the first match instead of
        // rotating it, so after the walk the survivors are back in their original order.
        if (steps_q == '0) begin
          st_d    = found_q ? STATUS_OK : STATUS_MISSING;
          state_d = ST_DONE;
        end else begin
          steps_d = steps_q - 1'b1;
          found_d = found_q | hit;
          if (hit && (kind_q == KIND_REMOVE)) begin
            cmd_o.op = CELL_SHIFT;
            cnt_d    = cnt_q - 1'b1;
          end else begin
            cmd_o.op      = CELL_ROTATE;
            cmd_o.set_ref = hit && (kind_q == KIND_REFERENCE);
          end
        end
      end
      ST_SORT: begin
        if (steps_q == '0) begin
          cmd_o.op = CELL_CLEAR;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = CELL_SORT;
          phase_d  = ~phase_q;
          steps_d  = steps_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_vf_d    = vf_q;
          out_vv_d    = vv_q;
          out_st_d    = st_q;
          out_occ_d   = OCC_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      steps_q     <= '0;
      phase_q     <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      steps_q     <= steps_d;
      phase_q     <= phase_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    frame_q   <= frame_d;
    vf_q      <= vf_d;
    vv_q      <= vv_d;
    st_q      <= st_d;
    out_vf_q  <= out_vf_d;
    out_vv_q  <= out_vv_d;
    out_st_q  <= out_st_d;
    out_occ_q <= out_occ_d;
  end

  assign in_ready_o         = (state_q == ST_IDLE);
  assign cnt_o              = cnt_q;
  assign out_valid_o        = out_valid_q;
  assign out_victim_frame_o = out_vf_q;
  assign out_victim_valid_o = out_vv_q;
  assign out_status_o       = out_st_q;
  assign out_occ_o          = out_occ_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FramesC)
    else $error("entry count above capacity");

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK || state_q == ST_SORT) |-> steps_q <= cnt_q)
    else $error("walk counter exceeds list length");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_kind_i == KIND_INSERT && cnt_q != FramesC)
      |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
    else $error("insert did not grow the list");

  a_sort_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT) |=> cnt_q == $past(cnt_q))
    else $error("partition changed the entry count");

  a_victim_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_vv_q) |-> out_st_q == STATUS_OK)
    else $error("victim reported with an error status");
`endif

endmodule

FILE: rtl/core/page_replacement_ref_reorder_top.sv
// Top level of the second-chance replacement list: a row of prr_cell positions and a prr_ctrl.
// Depends on prr_pkg, prr_cell and prr_ctrl.
//
// Usage: requests arrive on the slave stream. tuser carries the request kind (insert,
// remove, reference, victim, tick); tdata carries the frame number and the referenced bit
// for an insert. Each request beat yields exactly one result beat on the master stream
// with the popped victim frame, a victim flag, a status code and the occupancy afterward.
// Insert, victim and unused kinds go from acceptance straight to the result state;
// remove and reference pass through the walk state and a tick through the sort state.
// Remove and reference rotate the whole list past the head cell once, one position per
// cycle; the tick runs N rounds of odd-even transposition across the cell row, where N
// is the number of entries at acceptance, and then clears every referenced bit. One
// request is in flight at a time, so the next request is taken in the cycle after the
// result is loaded.
// Reset empties the list and clears all referenced bits; no clearing pass is needed.
// If the receiver stalls, the result stays in the output register and the block can
// still take and work on the next request; it then waits to load its own result.
module page_replacement_ref_reorder_top
  import prr_pkg::*;
#(
  parameter int unsigned FRAMES = FramesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [5:0] frame, [6] initial_ref, [7] zero fill
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] kind
  // Result stream.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [5:0] victim_frame, [6] victim_valid,
                                        // [8:7] status, [15:9] occupancy
);

  localparam int unsigned CntW = $clog2(FRAMES + 1);

  // The cell row: position 0 is the head of the replacement order.
  logic [FRAME_W-1:0]  cell_frame [FRAMES];
  logic                cell_ref   [FRAMES];
  cell_cmd_t           cmd;
  logic [CntW-1:0]     cnt;
  logic [FRAME_W-1:0]  res_vf;
  logic                res_vv;
  logic [STATUS_W-1:0] res_st;
  logic [OCC_W-1:0]    res_occ;

  prr_ctrl #(
    .FRAMES(FRAMES)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (s_axis_tvalid_i),
    .in_ready_o         (s_axis_tready_o),
    .in_kind_i          (s_axis_tuser_i),
    .in_frame_i         (s_axis_tdata_i[5:0]),
    .in_iref_i          (s_axis_tdata_i[6]),
    .head_frame_i       (cell_frame[0]),
    .cmd_o              (cmd),
    .cnt_o              (cnt),
    .out_valid_o        (m_axis_tvalid_o),
    .out_ready_i        (m_axis_tready_i),
    .out_victim_frame_o (res_vf),
    .out_victim_valid_o (res_vv),
    .out_status_o       (res_st),
    .out_occ_o          (res_occ)
  );

  // Each cell sees its two neighbors and the head; the ends of the row see zeros.
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    logic [FRAME_W-1:0] right_frame, left_frame;
    logic               right_ref, left_ref;

    if (g == FRAMES - 1) begin : g_tail
      assign right_frame = '0;
      assign right_ref   = 1'b0;
    end else begin : g_body
      assign right_frame = cell_frame[g+1];
      assign right_ref   = cell_ref[g+1];
    end

    if (g == 0) begin : g_head
      assign left_frame = '0;
      assign left_ref   = 1'b0;
    end else begin : g_rest
      assign left_frame = cell_frame[g-1];
      assign left_ref   = cell_ref[g-1];
    end

    prr_cell #(
      .FRAMES(FRAMES),
      .IDX   (g)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .cnt_i         (cnt),
      .head_frame_i  (cell_frame[0]),
      .head_ref_i    (cell_ref[0]),
      .right_frame_i (right_frame),
      .right_ref_i   (right_ref),
      .left_frame_i  (left_frame),
      .left_ref_i    (left_ref),
      .frame_o       (cell_frame[g]),
      .ref_o         (cell_ref[g])
    );
  end

  assign m_axis_tdata_o = {res_occ, res_st, res_vv, res_vf};

endmodule
